// ===== rtl/s2d_pkg.sv =====
`default_nettype none
package s2d_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned PROD_W      = 2 * VALUE_W;
  localparam int unsigned QUOT_SHIFT  = 35;
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int unsigned POS_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // ceil(2^35 / 10): q = (m * RECIP_10) >> 35 is exact for every 32-bit m
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam logic [7:0]         ASCII_ZERO  = 8'd48;
  localparam logic [7:0]         ASCII_MINUS = 8'd45;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } s2d_item_t;

endpackage
`default_nettype wire

// ===== rtl/s2d_front.sv =====
`default_nettype none
module s2d_front #(
  parameter int unsigned DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [s2d_pkg::VALUE_W-1:0] in_value,
  output logic                             q_valid,
  input  wire logic                        q_pop,
  output s2d_pkg::s2d_item_t               q_item
);
  import s2d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  s2d_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  s2d_item_t            cls;
  logic                 do_push, do_pop;

  // classify: sign and unsigned magnitude (most negative value wraps to 2^31)
  always_comb begin
    cls.neg = in_value[VALUE_W-1];
    cls.mag = cls.neg ? (~in_value + VALUE_W'(1)) : in_value;
  end

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/s2d_back.sv =====
`default_nettype none
module s2d_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire s2d_pkg::s2d_item_t         q_item,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [7:0]                      out_text_char,
  output logic [s2d_pkg::POS_W-1:0]       out_char_position,
  output logic                            out_is_last
);
  import s2d_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  localparam int unsigned QUOT_W = PROD_W - QUOT_SHIFT;

  state_t               state_r, state_nxt;
  logic                 neg_r, neg_nxt;
  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic [PROD_W-1:0]    prod_r;
  logic [DIG_IDX_W-1:0] ndig_r, ndig_nxt;
  logic [DIG_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     total_r, total_nxt;
  logic [3:0]           digits_r [MAX_DIGITS];
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           char_r, char_nxt;
  logic [POS_W-1:0]     opos_r, opos_nxt;
  logic                 last_r, last_nxt;
  logic [QUOT_W-1:0]    quot;
  logic [VALUE_W-1:0]   quot10;
  logic [3:0]           rem;
  logic                 dig_we;
  logic                 slot_free;
  logic                 is_last_char;

  assign quot      = prod_r[PROD_W-1:QUOT_SHIFT];
  assign quot10    = VALUE_W'({quot, 3'b000}) + VALUE_W'({quot, 1'b0});
  assign rem       = 4'(mag_r - quot10);
  assign slot_free = !out_valid_r || pop;
  assign is_last_char = ((pos_r + POS_W'(1)) == total_r);

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    ndig_nxt      = ndig_r;
    rd_idx_nxt    = rd_idx_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !pop;
    char_nxt      = char_r;
    opos_nxt      = opos_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    dig_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          neg_nxt   = q_item.neg;
          mag_nxt   = q_item.mag;
          ndig_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // store one digit, least significant first
        dig_we   = 1'b1;
        ndig_nxt = ndig_r + DIG_IDX_W'(1);
        mag_nxt  = VALUE_W'(quot);
        if (quot == '0) begin
          rd_idx_nxt = ndig_r;
          pos_nxt    = '0;
          total_nxt  = POS_W'(ndig_r) + POS_W'(1) + POS_W'(neg_r);
          state_nxt  = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          opos_nxt      = pos_r;
          last_nxt      = is_last_char;
          pos_nxt       = pos_r + POS_W'(1);
          if (neg_r && (pos_r == '0)) begin
            char_nxt = ASCII_MINUS;
          end else begin
            char_nxt   = ASCII_ZERO + 8'(digits_r[rd_idx_r]);
            rd_idx_nxt = rd_idx_r - DIG_IDX_W'(1);
          end
          if (is_last_char) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    prod_r   <= mag_r * RECIP_10;
    ndig_r   <= ndig_nxt;
    rd_idx_r <= rd_idx_nxt;
    pos_r    <= pos_nxt;
    total_r  <= total_nxt;
    char_r   <= char_nxt;
    opos_r   <= opos_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      digits_r[ndig_r] <= rem;
    end
  end

  assign empty             = !out_valid_r;
  assign out_text_char     = char_r;
  assign out_char_position = opos_r;
  assign out_is_last       = last_r;

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none
// Channel   Handshake        Payload                                   Beat
// input     push / full      in_value[31:0] signed                     one integer
// result    empty / pop      out_text_char[7:0], out_char_position[3:0],
//                            out_is_last                               one character
//
// Flow: the back end takes an item from the input queue, runs the divide-by-ten
// loop once per decimal digit (multiply by reciprocal, then quotient and
// remainder), then emits the characters one at a time, sign first on negative
// values, and takes the next item only after its last character. The shared
// reciprocal multiplier sets the digit loop.
// Reset: synchronous on rst_n low; clears the input queue and the result slot.
// Stalls: the input queue keeps accepting while the back end works; a held
// result beat stalls only character emission.
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [s2d_pkg::VALUE_W-1:0] in_value,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_text_char,
  output logic [s2d_pkg::POS_W-1:0]        out_char_position,
  output logic                             out_is_last
);
  import s2d_pkg::*;

  logic      q_valid;
  logic      q_pop;
  s2d_item_t q_item;

  // front: classify sign and magnitude, hold items in a short queue
  s2d_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: peel digits off by ten, then drive characters most significant first
  s2d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .empty             (empty),
    .pop               (pop),
    .out_text_char     (out_text_char),
    .out_char_position (out_char_position),
    .out_is_last       (out_is_last)
  );

endmodule
`default_nettype wire

// ===== rtl/s2d_checker.sv =====
`default_nettype none
module s2d_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_text_char,
  input wire logic [3:0] out_char_position,
  input wire logic       out_is_last
);
  import s2d_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_text_char)
                          && $stable(out_char_position) && $stable(out_is_last)))
    else $error("stalled result beat changed");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_text_char == ASCII_MINUS ||
                (out_text_char >= ASCII_ZERO && out_text_char <= ASCII_ZERO + 8'd9)))
    else $error("character outside sign and digits");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_text_char == ASCII_MINUS) |-> (out_char_position == 4'd0 && !out_is_last))
    else $error("minus sign out of place");

  a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_char_position == 4'd10) |-> out_is_last)
    else $error("string longer than eleven characters");

endmodule

bind signed_int_to_decimal_ascii_unit s2d_checker u_s2d_checker (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import s2d_pkg::*;

  // Character beat as it leaves the block: ASCII code, string index, last flag.
  typedef struct packed {
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    logic             last;
  } text_beat_t;

  localparam logic [VALUE_W-1:0] DEC_BASE = 10;
  localparam int KNOWN_COUNT  = 22;
  localparam int RANDOM_ITEMS = 340;
  localparam int BLOCK_ITEMS  = 40;   // random items per idling phase
  localparam int HOLD_AT      = 300;  // beats taken before the long receiver hold
  localparam int HOLD_CYCLES  = 300;  // length of that hold
  localparam int DRAIN_CYCLES = 40;   // above the worst item latency

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               push     = 1'b0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               pop      = 1'b0;
  logic               full;
  logic               empty;
  logic [7:0]         out_text_char;
  logic [POS_W-1:0]   out_char_position;
  logic               out_is_last;

  // Characters still owed by the block, oldest first.
  text_beat_t pending_chars[$];
  int         mismatch_count = 0;
  // Shared by both sides: high during a stretch with no idling at all.
  bit         no_idle = 1'b0;

  // Directed rows. A typed string is the expected text; an empty one sends the
  // row through the decimal predictor instead.
  logic [VALUE_W-1:0] known_values [KNOWN_COUNT] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd999999999,
    32'd1000000000, -32'sd1000000000, 32'd1234567890,
    32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'h7FFF_FFF0,
    32'h0F0F_0F0F, 32'hF0F0_F0F0
  };
  string known_texts [KNOWN_COUNT] = '{
    "0", "1", "-1", "9", "-9", "10", "-10", "99", "100",
    "2147483647", "-2147483648", "-2147483647", "999999999",
    "1000000000", "-1000000000", "1234567890",
    "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_value         (in_value),
    .empty            (empty),
    .pop              (pop),
    .out_text_char    (out_text_char),
    .out_char_position(out_char_position),
    .out_is_last      (out_is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Queue one expected character at index pos of a string total characters long.
  function automatic void add_char(input logic [7:0] ch, input int pos, input int total);
    text_beat_t beat;
    beat.ch   = ch;
    beat.pos  = pos[POS_W-1:0];
    beat.last = (pos == total - 1);
    pending_chars.push_back(beat);
  endfunction

  // Decimal predictor: form the magnitude as an unsigned word so the most
  // negative value spells out in full, peel digits off the bottom, then emit
  // sign and digits most significant first.
  function automatic void spell_decimal(input logic [VALUE_W-1:0] value);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digit [MAX_DIGITS];
    int                 ndig;
    int                 total;
    int                 k;
    neg  = value[VALUE_W-1];
    mag  = neg ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digit[ndig] = 4'(mag % DEC_BASE);
      mag         = mag / DEC_BASE;
      ndig++;
    end while (mag != 0);
    total = ndig + int'(neg);
    k     = 0;
    if (neg) begin
      add_char(ASCII_MINUS, k, total);
      k++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      add_char(ASCII_ZERO + 8'(digit[i]), k, total);
      k++;
    end
  endfunction

  // Random integer: mostly a uniformly chosen digit count and sign, with the
  // range ends of each length, plus raw words so every bit toggles.
  function automatic logic [VALUE_W-1:0] draw_value();
    logic   neg;
    int     ndig;
    longint lo;
    longint hi;
    longint mag;
    neg  = 1'($urandom_range(0, 1));
    ndig = $urandom_range(1, MAX_DIGITS);
    hi   = 1;
    for (int i = 0; i < ndig; i++) hi = hi * 10;
    lo = (ndig == 1) ? 0 : hi / 10;
    hi = hi - 1;
    // cap the ten-digit class at the widest magnitude this sign allows
    if (hi > 64'd2147483647 + longint'(neg)) hi = 64'd2147483647 + longint'(neg);
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: mag = lo;
      2: mag = hi;
      default: mag = lo + (longint'($urandom) % (hi - lo + 1));
    endcase
    return neg ? -mag[VALUE_W-1:0] : mag[VALUE_W-1:0];
  endfunction

  // Offer one integer after a random gap and hold it until the block takes it.
  // Push stays high straight into the next beat when the gap is zero, so it
  // never drops and rises within one step.
  task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push     <= 1'b0;
      in_value <= $urandom;   // drive junk while idle; the block must ignore it
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (full);
    // beat taken at this edge: record what it must turn into
    if (text.len() == 0) begin
      spell_decimal(value);
    end else begin
      for (int i = 0; i < text.len(); i++) add_char(text[i], i, text.len());
    end
  endtask

  // Receiver: random stall before each beat, none during quiet stretches, and
  // one long hold so the block backs up and raises full on the input side.
  initial begin : take_chars
    int gap;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  // Check each character beat against the oldest expectation, field by field.
  always @(posedge clk) begin : check_chars
    text_beat_t want;
    if (rst_n && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h pos %0d last %0b",
                                  out_text_char, out_char_position, out_is_last));
      end else begin
        want = pending_chars.pop_front();
        if (out_text_char !== want.ch)
          report_mismatch($sformatf("text_char 0x%02h, want 0x%02h",
                                    out_text_char, want.ch));
        if (out_char_position !== want.pos)
          report_mismatch($sformatf("char_position %0d, want %0d",
                                    out_char_position, want.pos));
        if (out_is_last !== want.last)
          report_mismatch($sformatf("is_last %0b, want %0b", out_is_last, want.last));
      end
    end
  end

  // Main sequence: reset, directed rows, random phases, drain, verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < KNOWN_COUNT; i++) send_value(known_values[i], known_texts[i]);

    // alternate idling phases with stretches of back-to-back beats
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = ((n / BLOCK_ITEMS) % 3 == 2);
      send_value(draw_value(), "");
    end
    push    <= 1'b0;
    no_idle = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    // leave room for any stray beat to show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every item at eleven
  // characters, every beat behind the longest stall, plus the long hold).
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
